@@ sv/crr_pkg.sv @@
package crr_pkg;

    // fixed field widths, step-count reset value and minimum, command queue depth
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 5;
    localparam logic [CFG_W-1:0] SPS_RESET = 5'd5;
    localparam int SPS_MIN  = 2;
    localparam int CQ_DEPTH = 4;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        logic   last_point;
    } t_in;

    typedef struct packed {
        t_coord sample_x;
        t_coord sample_y;
        t_coord sample_z;
        logic   path_end;
    } t_out;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pt;

    // one unit of work for the back end: a span or a plain point
    typedef struct packed {
        logic is_point;
        logic path_end;
        t_pt  p0;
        t_pt  p1;
        t_pt  p2;
        t_pt  p3;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_wr;

    typedef struct packed {
        logic ready;
        t_cmd cmd;
    } t_cmd_rd;

    // pick one axis of a point
    function automatic t_coord pt_lane(t_pt p, logic [1:0] i);
        t_coord v;
        unique case (i)
            2'd0:    v = p.x;
            2'd1:    v = p.y;
            default: v = p.z;
        endcase
        return v;
    endfunction

    function automatic t_pt in_pt(t_in d);
        t_pt p;
        p.x = d.point_x;
        p.y = d.point_y;
        p.z = d.point_z;
        return p;
    endfunction

endpackage

@@ sv/crr_front.sv @@
module crr_front #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  crr_pkg::t_in           i_item,
    output logic                   o_full,
    input  logic                   i_cfg_we,
    input  logic [crr_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic [$clog2(MAX_SAMPLES+1)-1:0] o_steps,
    input  logic                   i_q_room,
    output crr_pkg::t_cmd_wr       o_wr
);
    import crr_pkg::*;

    localparam int SW = $clog2(MAX_SAMPLES+1);

    typedef enum logic [1:0] {SEEN_NONE, SEEN_ONE, SEEN_TWO, SEEN_MORE} t_seen;

    logic [CFG_W-1:0] r_sps;
    t_seen            r_seen;
    t_pt              r_p0, r_p1, r_p2;
    logic             r_pend;
    t_cmd             r_pend_cmd;

    logic accept;
    t_pt  p;
    t_cmd n_cmd;
    logic n_valid;

    // clamp of the step count
    always_comb begin
        if (r_sps < CFG_W'(SPS_MIN)) begin
            o_steps = SW'(SPS_MIN);
        end else if (int'(r_sps) > MAX_SAMPLES) begin
            o_steps = SW'(MAX_SAMPLES);
        end else begin
            o_steps = SW'(r_sps);
        end
    end

    assign o_full = r_pend || !i_q_room;
    assign accept = i_push && !o_full;
    assign p      = in_pt(i_item);

    // classify the incoming waypoint
    always_comb begin
        n_cmd.is_point = 1'b1;
        n_cmd.path_end = i_item.last_point;
        n_cmd.p0       = p;
        n_cmd.p1       = p;
        n_cmd.p2       = p;
        n_cmd.p3       = p;
        n_valid        = 1'b0;
        unique case (r_seen)
            SEEN_NONE: begin
                n_valid = 1'b1;
            end
            SEEN_ONE: begin
                n_valid        = i_item.last_point;
                n_cmd.path_end = 1'b1;
            end
            default: begin
                n_valid        = 1'b1;
                n_cmd.is_point = 1'b0;
                n_cmd.path_end = 1'b0;
                n_cmd.p0       = r_p0;
                n_cmd.p1       = r_p1;
                n_cmd.p2       = r_p2;
            end
        endcase
    end

    assign o_wr.valid = r_pend || (accept && n_valid);
    assign o_wr.cmd   = r_pend ? r_pend_cmd : n_cmd;

    // waypoint history, path state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps  <= SPS_RESET;
            r_seen <= SEEN_NONE;
            r_pend <= 1'b0;
            r_p0   <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sps <= i_cfg_wdata;
            end
            if (r_pend) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                unique case (r_seen)
                    SEEN_NONE: begin
                        r_p0   <= p;
                        r_p1   <= p;
                        r_p2   <= p;
                        r_seen <= i_item.last_point ? SEEN_NONE : SEEN_ONE;
                    end
                    SEEN_ONE: begin
                        r_p0   <= r_p1;
                        r_p1   <= r_p2;
                        r_p2   <= p;
                        r_seen <= i_item.last_point ? SEEN_NONE : SEEN_TWO;
                    end
                    default: begin
                        r_p0   <= r_p1;
                        r_p1   <= r_p2;
                        r_p2   <= p;
                        r_seen <= i_item.last_point ? SEEN_NONE : SEEN_MORE;
                        // closing span with the end point repeated
                        r_pend              <= i_item.last_point;
                        r_pend_cmd.is_point <= 1'b0;
                        r_pend_cmd.path_end <= 1'b1;
                        r_pend_cmd.p0       <= r_p1;
                        r_pend_cmd.p1       <= r_p2;
                        r_pend_cmd.p2       <= p;
                        r_pend_cmd.p3       <= p;
                    end
                endcase
            end
        end
    end

endmodule

@@ sv/crr_cmdq.sv @@
module crr_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crr_pkg::t_cmd_wr i_wr,
    output logic             o_room,
    output crr_pkg::t_cmd_rd o_rd,
    input  logic             i_pop
);
    import crr_pkg::*;

    localparam int AW = $clog2(CQ_DEPTH);
    localparam int NW = $clog2(CQ_DEPTH+1);

    t_cmd          r_mem [CQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    // room for the two commands one waypoint can make
    assign o_room     = r_cnt <= NW'(CQ_DEPTH-2);
    assign o_rd.ready = r_cnt != '0;
    assign o_rd.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wp] <= i_wr.cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (i_wr.valid && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (!i_wr.valid && i_pop) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

@@ sv/crr_back.sv @@
module crr_back #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0] i_steps,
    input  crr_pkg::t_cmd_rd       i_rd,
    output logic                   o_pop,
    output logic                   o_empty,
    input  logic                   i_pop,
    output crr_pkg::t_out          o_sample
);
    import crr_pkg::*;

    localparam int SW = $clog2(MAX_SAMPLES+1);
    localparam int KW = 2*SW;
    localparam int WW = 3*SW;
    localparam int CW = COORD_W+4;
    localparam int AW = 64;
    localparam int PW = CW+WW+1;
    localparam int BW = $clog2(COORD_W);

    typedef enum logic [3:0] {
        B_IDLE, B_COEF, B_W1, B_W2, B_MAC, B_PREP, B_DIV, B_EMIT, B_FINAL
    } t_bstate;

    t_bstate                r_state;
    t_cmd                   r_cmd;
    logic [SW-1:0]          r_k;
    logic [KW-1:0]          r_ss, r_ks, r_kk;
    logic [WW-1:0]          r_w [4];
    logic signed [CW-1:0]   r_coef [3][4];
    logic signed [AW-1:0]   r_acc [3];
    logic [AW-1:0]          r_rem [3];
    logic                   r_neg [3];
    logic                   r_ovf [3];
    logic [COORD_W-1:0]     r_q [3];
    logic [AW-1:0]          r_dsh;
    logic [1:0]             r_term;
    logic [BW-1:0]          r_bit;
    t_out                   r_out;
    logic                   r_out_valid;

    logic signed [CW-1:0]   c_coef [3][4];
    logic signed [PW-1:0]   prod [3];
    logic [AW-1:0]          mag [3];
    logic                   ovf [3];
    logic                   ge [3];
    t_coord                 sat [3];
    logic [WW-1:0]          n_w0;
    logic [AW-1:0]          den;
    logic                   out_free;
    logic                   load_out;

    assign out_free = !r_out_valid || i_pop;
    assign load_out = out_free && ((r_state == B_EMIT) || (r_state == B_FINAL));
    assign o_pop    = (r_state == B_IDLE) && i_rd.ready;
    assign o_empty  = !r_out_valid;
    assign o_sample = r_out;
    assign n_w0     = WW'(r_ss) * WW'(i_steps);
    assign den      = AW'(r_w[0]) << 1;

    // span polynomial coefficients per axis
    always_comb begin
        logic signed [CW-1:0] a, b, c, d;
        for (int l = 0; l < 3; l++) begin
            a = CW'(pt_lane(r_cmd.p0, 2'(l)));
            b = CW'(pt_lane(r_cmd.p1, 2'(l)));
            c = CW'(pt_lane(r_cmd.p2, 2'(l)));
            d = CW'(pt_lane(r_cmd.p3, 2'(l)));
            c_coef[l][0] = b <<< 1;
            c_coef[l][1] = c - a;
            c_coef[l][2] = (a <<< 1) - ((b <<< 2) + b) + (c <<< 2) - d;
            c_coef[l][3] = ((b <<< 1) + b) - a - ((c <<< 1) + c) + d;
        end
    end

    // multiply, magnitude, divide step and saturation per axis
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            prod[l] = PW'(r_coef[l][r_term]) * PW'($signed({1'b0, r_w[r_term]}));
            mag[l]  = r_acc[l][AW-1] ? (den - AW'(1) - AW'(r_acc[l]))
                                     : AW'(r_acc[l]);
            ovf[l]  = mag[l] >= (den << COORD_W);
            ge[l]   = r_rem[l] >= r_dsh;
            if (!r_neg[l]) begin
                sat[l] = (r_ovf[l] || r_q[l][COORD_W-1])
                         ? {1'b0, {(COORD_W-1){1'b1}}} : r_q[l];
            end else begin
                sat[l] = (r_ovf[l] || (r_q[l][COORD_W-1] && (|r_q[l][COORD_W-2:0])))
                         ? {1'b1, {(COORD_W-1){1'b0}}} : (~r_q[l] + COORD_W'(1));
            end
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result slot: load wins over a pop of the old result
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_rd.ready) begin
                        r_cmd   <= i_rd.cmd;
                        r_k     <= SW'(1);
                        r_state <= B_COEF;
                    end
                end
                B_COEF: begin
                    r_coef  <= c_coef;
                    r_state <= r_cmd.is_point ? B_FINAL : B_W1;
                end
                B_W1: begin
                    r_ss    <= KW'(i_steps) * KW'(i_steps);
                    r_ks    <= KW'(r_k) * KW'(i_steps);
                    r_kk    <= KW'(r_k) * KW'(r_k);
                    r_state <= B_W2;
                end
                B_W2: begin
                    r_w[0] <= n_w0;
                    r_w[1] <= WW'(r_ks) * WW'(i_steps);
                    r_w[2] <= WW'(r_kk) * WW'(i_steps);
                    r_w[3] <= WW'(r_kk) * WW'(r_k);
                    for (int l = 0; l < 3; l++) begin
                        r_acc[l] <= $signed(AW'(n_w0));
                    end
                    r_term  <= '0;
                    r_state <= B_MAC;
                end
                B_MAC: begin
                    for (int l = 0; l < 3; l++) begin
                        r_acc[l] <= r_acc[l] + AW'(prod[l]);
                    end
                    r_term <= r_term + 2'd1;
                    if (r_term == 2'd3) begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    for (int l = 0; l < 3; l++) begin
                        r_rem[l] <= mag[l];
                        r_neg[l] <= r_acc[l][AW-1];
                        r_ovf[l] <= ovf[l];
                        r_q[l]   <= '0;
                    end
                    r_dsh   <= den << (COORD_W-1);
                    r_bit   <= BW'(COORD_W-1);
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    for (int l = 0; l < 3; l++) begin
                        if (ge[l]) begin
                            r_rem[l] <= r_rem[l] - r_dsh;
                        end
                        r_q[l] <= {r_q[l][COORD_W-2:0], ge[l]};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_bit <= r_bit - BW'(1);
                    if (r_bit == '0) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_out.sample_x <= sat[0];
                        r_out.sample_y <= sat[1];
                        r_out.sample_z <= sat[2];
                        r_out.path_end <= 1'b0;
                        if (r_k == i_steps - SW'(1)) begin
                            r_state <= B_FINAL;
                        end else begin
                            r_k     <= r_k + SW'(1);
                            r_state <= B_W1;
                        end
                    end
                end
                B_FINAL: begin
                    if (out_free) begin
                        r_out.sample_x <= r_cmd.p2.x;
                        r_out.sample_y <= r_cmd.p2.y;
                        r_out.sample_z <= r_cmd.p2.z;
                        r_out.path_end <= r_cmd.path_end;
                        r_state        <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/catmull_rom_path_resampler.sv @@
// back end: a plain point goes from the queue through the coefficient state to the
// output; each interpolated sample runs weights, multiply-accumulate of 4 terms,
// setup, 32 one-bit divide steps and output, after the span setup
// spans: one per waypoint from the third of a path on, two for the last one; the back
// end takes a command only when done with the last; a held result stalls the back end
// reset: synchronous active low; clears path state, the command queue and the result slot, and restores s to 5
module catmull_rom_path_resampler #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  crr_pkg::t_in               i_point,
    output logic                       empty,
    input  logic                       pop,
    output crr_pkg::t_out              o_sample,
    input  logic                       i_cfg_we,
    input  logic [crr_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import crr_pkg::*;

    localparam int SW = $clog2(MAX_SAMPLES+1);

    logic [SW-1:0] steps;
    logic          q_room;
    logic          q_pop;
    t_cmd_wr       q_wr;
    t_cmd_rd       q_rd;

    crr_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_point),
        .o_full      (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_steps     (steps),
        .i_q_room    (q_room),
        .o_wr        (q_wr)
    );

    crr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_room  (q_room),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    crr_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_steps  (steps),
        .i_rd     (q_rd),
        .o_pop    (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_sample (o_sample)
    );

endmodule

@@ sv/crr_checker.sv @@
module crr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input crr_pkg::t_out o_sample
);
    import crr_pkg::*;

    logic r_seen;

    // any transaction accepted since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (push && !full) begin
            r_seen <= 1'b1;
        end
    end

    // reset leaves both sides idle
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !full && empty)
        else $error("not idle after reset");

    // a waiting result holds until popped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_sample))
        else $error("result changed while waiting");

    // no result without an input transaction
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> empty)
        else $error("result before any input");

endmodule

bind catmull_rom_path_resampler crr_checker u_chk (.*);

@@ tb/crr_path_checker.sv @@
// watches both channels and the config port, predicts every sample and compares
module crr_path_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  crr_pkg::t_in              i_point,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  crr_pkg::t_out             i_sample,
    input  logic                      i_cfg_we,
    input  logic [crr_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    import crr_pkg::*;

    localparam int MAX_STEPS = 16;

    typedef longint t_triple [3];

    // predictor state
    logic [CFG_W-1:0] steps_reg;
    t_triple          hist [3];
    int               pts_in_path;
    t_out             sample_queue [$];

    assign o_pending = sample_queue.size();

    // rounded, saturated uniform spline value at u = k/s
    function automatic t_coord spline_coord(longint a, longint b, longint c, longint d,
                                            longint k, longint s);
        longint c0, c1, c2, c3, s3, num, den, q;
        c0  = 2 * b;
        c1  = c - a;
        c2  = 2 * a - 5 * b + 4 * c - d;
        c3  = 3 * b - a - 3 * c + d;
        s3  = s * s * s;
        num = c0 * s3 + c1 * k * s * s + c2 * k * k * s + c3 * k * k * k + s3;
        den = 2 * s3;
        q   = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return t_coord'(q);
    endfunction

    function automatic void queue_point(t_triple p, logic end_flag);
        t_out o;
        o.sample_x = t_coord'(p[0]);
        o.sample_y = t_coord'(p[1]);
        o.sample_z = t_coord'(p[2]);
        o.path_end = end_flag;
        sample_queue.insert(sample_queue.size(), o);
    endfunction

    // samples of the span p1 -> p2 followed by p2 itself
    function automatic void queue_span(t_triple p0, t_triple p1, t_triple p2, t_triple p3,
                                       int s, logic end_flag);
        t_out o;
        for (int k = 1; k < s; k++) begin
            o.sample_x = spline_coord(p0[0], p1[0], p2[0], p3[0], k, s);
            o.sample_y = spline_coord(p0[1], p1[1], p2[1], p3[1], k, s);
            o.sample_z = spline_coord(p0[2], p1[2], p2[2], p3[2], k, s);
            o.path_end = 1'b0;
            sample_queue.insert(sample_queue.size(), o);
        end
        queue_point(p2, end_flag);
    endfunction

    function automatic void shift_point(t_triple p);
        hist[0] = hist[1];
        hist[1] = hist[2];
        hist[2] = p;
    endfunction

    function automatic void predict_waypoint(t_in d);
        t_triple p;
        int      s;
        s = int'(steps_reg);
        if (s < SPS_MIN) s = SPS_MIN;
        if (s > MAX_STEPS) s = MAX_STEPS;
        p[0] = longint'(d.point_x);
        p[1] = longint'(d.point_y);
        p[2] = longint'(d.point_z);
        case (pts_in_path)
            0: begin
                hist[0] = p;
                hist[1] = p;
                hist[2] = p;
                queue_point(p, d.last_point);
                pts_in_path = d.last_point ? 0 : 1;
            end
            1: begin
                shift_point(p);
                if (d.last_point) begin
                    queue_point(p, 1'b1);
                    pts_in_path = 0;
                end else begin
                    pts_in_path = 2;
                end
            end
            default: begin
                queue_span(hist[0], hist[1], hist[2], p, s, 1'b0);
                shift_point(p);
                pts_in_path = 3;
                if (d.last_point) begin
                    queue_span(hist[0], hist[1], hist[2], hist[2], s, 1'b1);
                    pts_in_path = 0;
                end
            end
        endcase
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            steps_reg    <= SPS_RESET;
            pts_in_path  = 0;
            o_fail_count <= 0;
            sample_queue.delete();
            for (int i = 0; i < 3; i++) hist[i] = '{0, 0, 0};
        end else begin
            if (i_pop && !i_empty) begin
                if (sample_queue.size() == 0) begin
                    $error("unexpected sample x=%0d y=%0d z=%0d", i_sample.sample_x,
                           i_sample.sample_y, i_sample.sample_z);
                    errs = errs + 1;
                end else begin
                    want = sample_queue.pop_front();
                    if (want.sample_x !== i_sample.sample_x) begin
                        $error("sample_x: expected %0d, got %0d", want.sample_x,
                               i_sample.sample_x);
                        errs = errs + 1;
                    end
                    if (want.sample_y !== i_sample.sample_y) begin
                        $error("sample_y: expected %0d, got %0d", want.sample_y,
                               i_sample.sample_y);
                        errs = errs + 1;
                    end
                    if (want.sample_z !== i_sample.sample_z) begin
                        $error("sample_z: expected %0d, got %0d", want.sample_z,
                               i_sample.sample_z);
                        errs = errs + 1;
                    end
                    if (want.path_end !== i_sample.path_end) begin
                        $error("path_end: expected %0b, got %0b", want.path_end,
                               i_sample.path_end);
                        errs = errs + 1;
                    end
                end
            end
            if (i_push && !i_full) predict_waypoint(i_point);
            if (i_cfg_we) steps_reg <= i_cfg_wdata;
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

@@ tb/tb_catmull_rom_path_resampler.sv @@
module tb_catmull_rom_path_resampler;
    import crr_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 60;
    localparam int PHASES      = 11;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    t_in              point;
    logic             empty;
    logic             pop;
    t_out             sample;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               cycle_count;

    catmull_rom_path_resampler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_point     (point),
        .empty       (empty),
        .pop         (pop),
        .o_sample    (sample),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    crr_path_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_point      (point),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_sample     (sample),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk) begin
        if (!rst_n) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("catmull_rom_path_resampler test failed");
            $finish;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(3))
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(8191)) - 4096);
            2: begin
                case ($urandom_range(3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return t_coord'($signed($urandom_range(2097151)) - 1048576);
        endcase
    endfunction

    // one input transaction, with random sender gaps
    task automatic send_point(t_coord x, t_coord y, t_coord z, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push             <= 1'b1;
        point.point_x    <= x;
        point.point_y    <= y;
        point.point_z    <= z;
        point.last_point <= last;
        do @(posedge clk); while (full);
    endtask

    task automatic send_random_path(int len);
        for (int i = 0; i < len; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
    endtask

    // drain, let the block settle, then write the step count
    task automatic write_steps(logic [CFG_W-1:0] v);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_steps [PHASES];
        int               phase_items [PHASES];
        int               left;
        int               len;
        phase_steps = '{5'd0, 5'd31, 5'd2, 5'd3, 5'd16, 5'd4, 5'd1, 5'd7, 5'd5, 5'd9, 5'd2};
        phase_items = '{30, 12, 60, 60, 10, 60, 40, 50, 60, 40, 48};
        rst_n       = 1'b0;
        push        = 1'b0;
        point       = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        tx_idle_pct = 38;
        rx_idle_pct = 67;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed paths at the reset step count
        send_point(32'sh80000000, 32'sh7fffffff, 32'sd0, 1'b1);          // single point
        send_point(32'sd256, -32'sd256, 32'sd1, 1'b0);                   // two points
        send_point(-32'sd1, 32'sd0, 32'sh7fffffff, 1'b1);
        send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);                        // three points
        send_point(32'sd1000, 32'sd2000, -32'sd3000, 1'b0);
        send_point(32'sd5000, -32'sd7, 32'sd12345, 1'b1);
        // alternating extremes drive the curve past the range
        for (int i = 0; i < 6; i++)
            send_point(i[0] ? 32'sh80000000 : 32'sh7fffffff,
                       i[0] ? 32'sh7fffffff : 32'sh80000000,
                       i[1] ? -32'sd1 : 32'sd0, i == 5);
        // ties in the rounding with tiny steps
        for (int i = 0; i < 5; i++)
            send_point(t_coord'(i), -t_coord'(i), t_coord'(i * i), i == 4);
        send_point(32'sh55555555, 32'shaaaaaaaa, 32'sh7fffffff, 1'b0);
        send_point(32'shaaaaaaaa, 32'sh55555555, 32'sh80000000, 1'b0);
        send_point(32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh00ff00ff, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 67;
                rx_idle_pct = 38;
            end else if (ph == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_steps(phase_steps[ph]);
            left = phase_items[ph];
            while (left > 0) begin
                case ($urandom_range(9))
                    0:       len = 1;
                    1:       len = 2;
                    default: len = $urandom_range(8, 3);
                endcase
                if (len > left) len = left;
                send_random_path(len);
                left = left - len;
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0) $display("catmull_rom_path_resampler test passed");
        else $display("catmull_rom_path_resampler test failed");
        $finish;
    end

endmodule
